// File: hw/rtl/qrr_pkg.sv
// Shared constants and types for the quadratic real-roots solver.
`default_nettype none
package qrr_pkg;
	localparam int WORD_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int TINY_W     = 16;
	localparam logic [TINY_W-1:0] TINY_RESET = TINY_W'(1);
	localparam int MODE_W     = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE   = 2'd0,
		MODE_LINEAR = 2'd1,
		MODE_DOUBLE = 2'd2,
		MODE_TWO    = 2'd3
	} mode_t;
endpackage
`default_nettype wire

// File: hw/rtl/qrr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module qrr_sqrt #(
	parameter int W      = qrr_pkg::WORD_WIDTH,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              vld_in,
	input  wire logic [2*W-1:0]    radicand,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   vld_out,
	output logic [W-1:0]           root,
	output logic [SIDE_W-1:0]      side_out
);
	logic [2*W-1:0]    rem_s  [1:W];
	logic [W-1:0]      root_s [1:W];
	logic [SIDE_W-1:0] side_s [1:W];
	logic              vld_s  [1:W];

	for (genvar i = 0; i < W; i++) begin : g_step
		localparam int K = W - 1 - i;
		logic [2*W-1:0]    rem_in;
		logic [W-1:0]      root_in;
		logic [SIDE_W-1:0] side_in_i;
		logic              vld_in_i;
		logic [2*W-1:0]    trial;
		logic              take;

		if (i == 0) begin : g_first
			assign rem_in    = radicand;
			assign root_in   = '0;
			assign side_in_i = side_in;
			assign vld_in_i  = vld_in;
		end else begin : g_next
			assign rem_in    = rem_s[i];
			assign root_in   = root_s[i];
			assign side_in_i = side_s[i];
			assign vld_in_i  = vld_s[i];
		end

		assign trial = ((2*W)'(root_in) << (K + 1)) | ((2*W)'(1) << (2 * K));
		assign take  = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_in_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1]  <= take ? rem_in - trial : rem_in;
				root_s[i+1] <= take ? (root_in | (W'(1) << K)) : root_in;
				side_s[i+1] <= side_in_i;
			end
		end
	end

	assign vld_out  = vld_s[W];
	assign root     = root_s[W];
	assign side_out = side_s[W];
endmodule
`default_nettype wire

// File: hw/rtl/qrr_div.sv
// Pipelined two-lane rounded divider with a shared divisor and saturation.
`default_nettype none
module qrr_div #(
	parameter int W      = qrr_pkg::WORD_WIDTH,
	parameter int NUM_W  = W + qrr_pkg::FRAC_BITS + 2,
	parameter int SIDE_W = 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic                    vld_in,
	input  wire logic signed [NUM_W-1:0] num1,
	input  wire logic signed [NUM_W-1:0] num2,
	input  wire logic signed [W-1:0]     den,
	input  wire logic [SIDE_W-1:0]       side_in,
	output logic                         vld_out,
	output logic signed [W-1:0]          quo1,
	output logic signed [W-1:0]          quo2,
	output logic                         sat1,
	output logic                         sat2,
	output logic [SIDE_W-1:0]            side_out
);
	localparam int CW = NUM_W + W;
	localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	// magnitude stage
	logic [NUM_W-1:0]  un_s1 [0:1];
	logic [W-1:0]      ud_s1;
	logic [1:0]        neg_s1;
	logic [SIDE_W-1:0] side_s1;
	logic              vld_s1;

	// step stages, index 0 holds the rounded dividend
	logic [NUM_W-1:0]  rem_s  [0:W][0:1];
	logic [W-1:0]      q_s    [0:W][0:1];
	logic [1:0]        ovf_s  [0:W];
	logic [1:0]        neg_s  [0:W];
	logic [W-1:0]      ud_s   [0:W];
	logic [SIDE_W-1:0] side_s [0:W];
	logic              vld_s  [0:W];

	logic              vld_s2;
	logic [SIDE_W-1:0] side_s2;
	logic [W-1:0]      quo_s2 [0:1];
	logic [1:0]        sat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s[0] <= 1'b0;
			vld_s2   <= 1'b0;
		end else if (adv) begin
			vld_s1   <= vld_in;
			vld_s[0] <= vld_s1;
			vld_s2   <= vld_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			un_s1[0]  <= num1[NUM_W-1] ? NUM_W'(-num1) : NUM_W'(num1);
			un_s1[1]  <= num2[NUM_W-1] ? NUM_W'(-num2) : NUM_W'(num2);
			ud_s1     <= den[W-1] ? W'(-den) : W'(den);
			neg_s1[0] <= num1[NUM_W-1] ^ den[W-1];
			neg_s1[1] <= num2[NUM_W-1] ^ den[W-1];
			side_s1   <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				rem_s[0][l]    <= un_s1[l] + NUM_W'(ud_s1 >> 1);
				ovf_s[0][l]    <= CW'(un_s1[l] + NUM_W'(ud_s1 >> 1)) >= (CW'(ud_s1) << W);
				q_s[0][l]      <= '0;
			end
			neg_s[0]  <= neg_s1;
			ud_s[0]   <= ud_s1;
			side_s[0] <= side_s1;
		end
	end

	for (genvar i = 0; i < W; i++) begin : g_step
		localparam int K = W - 1 - i;
		logic [CW-1:0] dsh;
		assign dsh = CW'(ud_s[i]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 2; l++) begin
					if (CW'(rem_s[i][l]) >= dsh) begin
						rem_s[i+1][l] <= rem_s[i][l] - dsh[NUM_W-1:0];
						q_s[i+1][l]   <= q_s[i][l] | (W'(1) << K);
					end else begin
						rem_s[i+1][l] <= rem_s[i][l];
						q_s[i+1][l]   <= q_s[i][l];
					end
				end
				ovf_s[i+1]  <= ovf_s[i];
				neg_s[i+1]  <= neg_s[i];
				ud_s[i+1]   <= ud_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	// sign and clamp
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				if (!neg_s[W][l]) begin
					if (ovf_s[W][l] || q_s[W][l][W-1]) begin
						quo_s2[l] <= WMAX;
						sat_s2[l] <= 1'b1;
					end else begin
						quo_s2[l] <= q_s[W][l];
						sat_s2[l] <= 1'b0;
					end
				end else begin
					if (ovf_s[W][l] || (q_s[W][l][W-1] && |q_s[W][l][W-2:0])) begin
						quo_s2[l] <= WMIN;
						sat_s2[l] <= 1'b1;
					end else begin
						quo_s2[l] <= W'(-q_s[W][l]);
						sat_s2[l] <= 1'b0;
					end
				end
			end
			side_s2 <= side_s[W];
		end
	end

	assign vld_out  = vld_s2;
	assign quo1     = $signed(quo_s2[0]);
	assign quo2     = $signed(quo_s2[1]);
	assign sat1     = sat_s2[0];
	assign sat2     = sat_s2[1];
	assign side_out = side_s2;
endmodule
`default_nettype wire

// File: hw/rtl/quadratic_real_roots_core.sv
// Quadratic real-roots solver: top level with products, discriminant and root ordering.
// Throughput: one request per cycle unless a result-side stall holds the pipeline; the square root
// and the divider each retire one quotient or root bit per pipeline stage.
// A stall on the result side freezes the whole pipeline; nothing is dropped.
// Reset clears all valid bits and sets tiny_q to 1.
`default_nettype none
module quadratic_real_roots_core #(
	parameter int WORD_WIDTH = qrr_pkg::WORD_WIDTH,
	parameter int FRAC_BITS  = qrr_pkg::FRAC_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [qrr_pkg::TINY_W-1:0]    cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [WORD_WIDTH-1:0]  coef_a,
	input  wire logic signed [WORD_WIDTH-1:0]  coef_b,
	input  wire logic signed [WORD_WIDTH-1:0]  coef_c,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         root_count,
	output logic signed [WORD_WIDTH-1:0]       root_low,
	output logic signed [WORD_WIDTH-1:0]       root_high,
	output logic                               saturated
);
	localparam int W     = WORD_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int DW    = 2 * W + 1;
	localparam int TW    = qrr_pkg::TINY_W;
	localparam int T2W   = 2 * TW;
	localparam int NUM_W = W + F + 2;
	localparam int MW    = qrr_pkg::MODE_W;
	localparam int SQ_SIDE = MW + 3 * W;

	logic [TW-1:0] tiny_q;
	logic          adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiny_q <= qrr_pkg::TINY_RESET;
		end else if (cfg_we) begin
			tiny_q <= cfg_wdata;
		end
	end

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: products and near-zero tests
	logic signed [W:0]     a_x, b_x, t_x;
	logic signed [2*W-1:0] bsq_s1, ac_s1;
	logic [T2W-1:0]        t2_s1;
	logic                  quad_s1, lin_s1, vld_s1;
	logic signed [W-1:0]   a_s1, b_s1, c_s1;

	assign a_x = (W+1)'(coef_a);
	assign b_x = (W+1)'(coef_b);
	assign t_x = $signed({{(W+1-TW){1'b0}}, tiny_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bsq_s1  <= (2*W)'(coef_b) * (2*W)'(coef_b);
			ac_s1   <= (2*W)'(coef_a) * (2*W)'(coef_c);
			t2_s1   <= T2W'(tiny_q) * T2W'(tiny_q);
			quad_s1 <= (a_x > t_x) || (a_x < -t_x);
			lin_s1  <= (b_x > t_x) || (b_x < -t_x);
			a_s1    <= coef_a;
			b_s1    <= coef_b;
			c_s1    <= coef_c;
		end
	end

	// stage 2: discriminant and case selection
	logic signed [DW-1:0] dint, t2_x;
	qrr_pkg::mode_t       mode_d, mode_s2;
	logic [2*W-1:0]       rad_s2;
	logic signed [W-1:0]  a_s2, b_s2, c_s2;
	logic                 vld_s2;

	assign dint = DW'(bsq_s1 >>> 2) - DW'(ac_s1);
	assign t2_x = $signed({{(DW-T2W){1'b0}}, t2_s1});

	always_comb begin
		if (quad_s1) begin
			if (dint < -t2_x) begin
				mode_d = qrr_pkg::MODE_NONE;
			end else if (dint < t2_x || (dint == t2_x && bsq_s1[1:0] == 2'b00)) begin
				mode_d = qrr_pkg::MODE_DOUBLE;
			end else begin
				mode_d = qrr_pkg::MODE_TWO;
			end
		end else if (lin_s1) begin
			mode_d = qrr_pkg::MODE_LINEAR;
		end else begin
			mode_d = qrr_pkg::MODE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2 <= mode_d;
			rad_s2  <= dint[2*W-1:0];
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			c_s2    <= c_s1;
		end
	end

	// square root
	logic               sq_vld;
	logic [W-1:0]       sq_root;
	logic [SQ_SIDE-1:0] sq_side;

	qrr_sqrt #(
		.W      (W),
		.SIDE_W (SQ_SIDE)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_in   (vld_s2),
		.radicand ((mode_s2 == qrr_pkg::MODE_TWO) ? rad_s2 : '0),
		.side_in  ({mode_s2, a_s2, b_s2, c_s2}),
		.vld_out  (sq_vld),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// stage 3: numerators and divisor
	qrr_pkg::mode_t        sq_mode;
	logic signed [W-1:0]   sq_a, sq_b, sq_c;
	logic signed [W+2:0]   s_x, nb_x, t_lo, t_hi;
	logic signed [NUM_W-1:0] num1_d;
	logic signed [NUM_W-1:0] num1_s3, num2_s3;
	logic signed [W-1:0]   den_s3;
	logic [MW-1:0]         mode_s3;
	logic                  vld_s3;

	assign sq_mode = qrr_pkg::mode_t'(sq_side[SQ_SIDE-1 -: MW]);
	assign sq_a    = $signed(sq_side[3*W-1 -: W]);
	assign sq_b    = $signed(sq_side[2*W-1 -: W]);
	assign sq_c    = $signed(sq_side[W-1:0]);
	assign s_x     = $signed({3'b000, sq_root});
	assign nb_x    = -((W+3)'(sq_b));
	assign t_lo    = nb_x - (s_x <<< 1);
	assign t_hi    = nb_x + (s_x <<< 1);

	always_comb begin
		case (sq_mode)
			qrr_pkg::MODE_LINEAR: num1_d = NUM_W'(-((W+1)'(sq_c))) <<< F;
			qrr_pkg::MODE_DOUBLE: num1_d = NUM_W'(nb_x) <<< (F - 1);
			default:              num1_d = NUM_W'(t_lo) <<< (F - 1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num1_s3 <= num1_d;
			num2_s3 <= NUM_W'(t_hi) <<< (F - 1);
			den_s3  <= (sq_mode == qrr_pkg::MODE_LINEAR) ? sq_b : sq_a;
			mode_s3 <= sq_mode;
		end
	end

	// division
	logic                dv_vld, dv_sat1, dv_sat2;
	logic signed [W-1:0] dv_q1, dv_q2;
	logic [MW-1:0]       dv_side;
	qrr_pkg::mode_t      dv_mode;

	qrr_div #(
		.W      (W),
		.NUM_W  (NUM_W),
		.SIDE_W (MW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_in   (vld_s3),
		.num1     (num1_s3),
		.num2     (num2_s3),
		.den      (den_s3),
		.side_in  (mode_s3),
		.vld_out  (dv_vld),
		.quo1     (dv_q1),
		.quo2     (dv_q2),
		.sat1     (dv_sat1),
		.sat2     (dv_sat2),
		.side_out (dv_side)
	);

	assign dv_mode = qrr_pkg::mode_t'(dv_side);

	// output register: ordering and masking
	logic                out_valid_q, sat_q;
	logic [1:0]          count_q;
	logic signed [W-1:0] low_q, high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (dv_mode)
				qrr_pkg::MODE_LINEAR, qrr_pkg::MODE_DOUBLE: begin
					count_q <= 2'd1;
					low_q   <= dv_q1;
					high_q  <= dv_q1;
					sat_q   <= dv_sat1;
				end
				qrr_pkg::MODE_TWO: begin
					count_q <= 2'd2;
					low_q   <= (dv_q1 <= dv_q2) ? dv_q1 : dv_q2;
					high_q  <= (dv_q1 <= dv_q2) ? dv_q2 : dv_q1;
					sat_q   <= dv_sat1 | dv_sat2;
				end
				default: begin
					count_q <= 2'd0;
					low_q   <= '0;
					high_q  <= '0;
					sat_q   <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign root_count = count_q;
	assign root_low   = low_q;
	assign root_high  = high_q;
	assign saturated  = sat_q;

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_count == 2'd0 |-> root_low == '0 && root_high == '0 && !saturated)
		else $error("no-root result carries nonzero fields");

	a_one_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_count == 2'd1 |-> root_low == root_high)
		else $error("single root differs between fields");

	a_two_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_count == 2'd2 |-> root_low <= root_high)
		else $error("roots out of order");

	a_free_in: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");
endmodule
`default_nettype wire
